// ===== rtl/tmp_pkg.sv =====
`timescale 1ns / 1ps

package tmp_pkg;

  // Fixed point format of angles and trig values
  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_STEPS    = 32;

  localparam int WORD_W  = ANGLE_FRAC_BITS + 10;
  localparam int TRIG_W  = ANGLE_FRAC_BITS + 3;
  localparam int NAB_W   = ANGLE_FRAC_BITS + 6;
  localparam int NORM_W  = $clog2(ANGLE_FRAC_BITS + 1);
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int OUT_W   = 32;
  localparam int K_W     = 34;
  localparam int RCM_W   = 30;
  localparam int RAD_SHIFT = 62 - ANGLE_FRAC_BITS;

  // Pipeline depths
  localparam int SC_LAT   = CORDIC_STEPS + 2;
  localparam int VEC_LAT  = CORDIC_STEPS + 1;
  localparam int PIPE_LAT = 2 * CORDIC_STEPS + 10;

  // Configuration register index (byte address bit 2)
  typedef enum logic {
    REG_ORIGIN_LAT = 1'b0,
    REG_ORIGIN_LON = 1'b1
  } reg_idx_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t word_tab_t [CORDIC_STEPS];
  typedef int shift_tab_t [CORDIC_STEPS];

  // One CORDIC lane
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } lane_t;

  localparam real PI_R  = 4.0 * $atan(1.0);
  localparam real ONE_R = 2.0 ** ANGLE_FRAC_BITS;

  function automatic word_t to_word(input real v);
    return word_t'(longint'(v));
  endfunction

  // Hyperbolic shift sequence with repeats at 4, 13, 40, ...
  function automatic shift_tab_t build_hyp_shift();
    shift_tab_t t;
    int i;
    int rep;
    bit again;
    i = 1;
    rep = 4;
    again = 1'b0;
    for (int n = 0; n < CORDIC_STEPS; n++) begin
      t[n] = i;
      if (i == rep && !again) begin
        again = 1'b1;
      end else begin
        if (i == rep) begin
          rep = 3 * rep + 1;
          again = 1'b0;
        end
        i++;
      end
    end
    return t;
  endfunction

  localparam shift_tab_t HYP_SHIFT = build_hyp_shift();

  function automatic word_tab_t build_circ();
    word_tab_t t;
    for (int n = 0; n < CORDIC_STEPS; n++) begin
      t[n] = to_word($atan(2.0 ** (-n)) * ONE_R);
    end
    return t;
  endfunction

  function automatic word_tab_t build_hyp();
    word_tab_t t;
    for (int n = 0; n < CORDIC_STEPS; n++) begin
      t[n] = to_word($atanh(2.0 ** (-HYP_SHIFT[n])) * ONE_R);
    end
    return t;
  endfunction

  localparam word_tab_t CIRC_TAB = build_circ();
  localparam word_tab_t HYP_TAB  = build_hyp();

  localparam word_t ONE_W      = word_t'(longint'(1) << ANGLE_FRAC_BITS);
  localparam word_t PI_W       = to_word(PI_R * ONE_R);
  localparam word_t HALF_PI_W  = to_word(PI_R / 2.0 * ONE_R);
  localparam word_t HALF_LN2_W = to_word($ln(2.0) / 2.0 * ONE_R);

  localparam logic [63:0] INV_GAIN_Q62 = 64'd2800459870029452954;
  localparam word_t INV_GAIN_W =
    word_t'((INV_GAIN_Q62 + (64'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT);

  // Degrees (1e-7) to radians scale in Q62
  localparam logic [K_W-1:0] RAD_K = K_W'(longint'(PI_R * (2.0 ** 62) / 1.8e9));

  localparam logic [RCM_W-1:0] R_CM = RCM_W'(637300000);
  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;

  localparam logic signed [LON_W:0] DL_HALF = 33'sd1800000000;
  localparam logic signed [LON_W:0] DL_FULL = 33'sd3600000000;

endpackage

// ===== rtl/tmp_sincos.sv =====
`timescale 1ns / 1ps

module tmp_sincos (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_in,
  input  tmp_pkg::word_t                      angle,
  output logic                                valid_out,
  output logic signed [tmp_pkg::TRIG_W-1:0]   sin_out,
  output logic signed [tmp_pkg::TRIG_W-1:0]   cos_out
);

  tmp_pkg::word_t x_r [tmp_pkg::CORDIC_STEPS+1];
  tmp_pkg::word_t y_r [tmp_pkg::CORDIC_STEPS+1];
  tmp_pkg::word_t z_r [tmp_pkg::CORDIC_STEPS+1];
  logic           neg_r [tmp_pkg::CORDIC_STEPS+1];
  logic           vld_r [tmp_pkg::CORDIC_STEPS+1];

  logic                              out_vld_r;
  logic signed [tmp_pkg::TRIG_W-1:0] sin_r;
  logic signed [tmp_pkg::TRIG_W-1:0] cos_r;

  // Fold the angle into the right half plane and seed the rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= valid_in;
    end
    x_r[0] <= tmp_pkg::INV_GAIN_W;
    y_r[0] <= '0;
    if (angle > tmp_pkg::HALF_PI_W) begin
      z_r[0]   <= angle - tmp_pkg::PI_W;
      neg_r[0] <= 1'b1;
    end else if (angle < -tmp_pkg::HALF_PI_W) begin
      z_r[0]   <= angle + tmp_pkg::PI_W;
      neg_r[0] <= 1'b1;
    end else begin
      z_r[0]   <= angle;
      neg_r[0] <= 1'b0;
    end
  end

  // One rotation step per stage
  for (genvar i = 0; i < tmp_pkg::CORDIC_STEPS; i++) begin : g_stage
    tmp_pkg::word_t dx;
    tmp_pkg::word_t dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      neg_r[i+1] <= neg_r[i];
      if (!z_r[i][tmp_pkg::WORD_W-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - tmp_pkg::CIRC_TAB[i];
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + tmp_pkg::CIRC_TAB[i];
      end
    end
  end

  // Undo the fold on the way out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[tmp_pkg::CORDIC_STEPS];
    end
    if (neg_r[tmp_pkg::CORDIC_STEPS]) begin
      sin_r <= tmp_pkg::TRIG_W'(-y_r[tmp_pkg::CORDIC_STEPS]);
      cos_r <= tmp_pkg::TRIG_W'(-x_r[tmp_pkg::CORDIC_STEPS]);
    end else begin
      sin_r <= tmp_pkg::TRIG_W'(y_r[tmp_pkg::CORDIC_STEPS]);
      cos_r <= tmp_pkg::TRIG_W'(x_r[tmp_pkg::CORDIC_STEPS]);
    end
  end

  assign valid_out = out_vld_r;
  assign sin_out   = sin_r;
  assign cos_out   = cos_r;

endmodule

// ===== rtl/tmp_vector.sv =====
`timescale 1ns / 1ps

module tmp_vector (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  input  tmp_pkg::word_t eps_x,
  input  tmp_pkg::word_t eps_y,
  input  tmp_pkg::word_t p_norm,
  input  tmp_pkg::word_t q_norm,
  output logic           valid_out,
  output tmp_pkg::word_t eps_z,
  output tmp_pkg::word_t p_z,
  output tmp_pkg::word_t q_z
);

  tmp_pkg::lane_t e_r [tmp_pkg::CORDIC_STEPS+1];
  tmp_pkg::lane_t p_r [tmp_pkg::CORDIC_STEPS+1];
  tmp_pkg::lane_t q_r [tmp_pkg::CORDIC_STEPS+1];
  logic           vld_r [tmp_pkg::CORDIC_STEPS+1];

  // Seed the circular lane and both hyperbolic lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= valid_in;
    end
    e_r[0] <= '{x: eps_x, y: eps_y, z: '0};
    p_r[0] <= '{x: p_norm + tmp_pkg::ONE_W, y: p_norm - tmp_pkg::ONE_W, z: '0};
    q_r[0] <= '{x: q_norm + tmp_pkg::ONE_W, y: q_norm - tmp_pkg::ONE_W, z: '0};
  end

  for (genvar n = 0; n < tmp_pkg::CORDIC_STEPS; n++) begin : g_stage
    localparam int HS = tmp_pkg::HYP_SHIFT[n];
    tmp_pkg::word_t edx, edy, pdx, pdy, qdx, qdy;
    assign edx = e_r[n].y >>> n;
    assign edy = e_r[n].x >>> n;
    assign pdx = p_r[n].y >>> HS;
    assign pdy = p_r[n].x >>> HS;
    assign qdx = q_r[n].y >>> HS;
    assign qdy = q_r[n].x >>> HS;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[n+1] <= 1'b0;
      end else begin
        vld_r[n+1] <= vld_r[n];
      end
      // Circular vectoring drives y toward zero
      if (!e_r[n].y[tmp_pkg::WORD_W-1]) begin
        e_r[n+1] <= '{x: e_r[n].x + edx, y: e_r[n].y - edy,
                      z: e_r[n].z + tmp_pkg::CIRC_TAB[n]};
      end else begin
        e_r[n+1] <= '{x: e_r[n].x - edx, y: e_r[n].y + edy,
                      z: e_r[n].z - tmp_pkg::CIRC_TAB[n]};
      end
      // Hyperbolic vectoring on both normalized terms
      if (!p_r[n].y[tmp_pkg::WORD_W-1]) begin
        p_r[n+1] <= '{x: p_r[n].x - pdx, y: p_r[n].y - pdy,
                      z: p_r[n].z + tmp_pkg::HYP_TAB[n]};
      end else begin
        p_r[n+1] <= '{x: p_r[n].x + pdx, y: p_r[n].y + pdy,
                      z: p_r[n].z - tmp_pkg::HYP_TAB[n]};
      end
      if (!q_r[n].y[tmp_pkg::WORD_W-1]) begin
        q_r[n+1] <= '{x: q_r[n].x - qdx, y: q_r[n].y - qdy,
                      z: q_r[n].z + tmp_pkg::HYP_TAB[n]};
      end else begin
        q_r[n+1] <= '{x: q_r[n].x + qdx, y: q_r[n].y + qdy,
                      z: q_r[n].z - tmp_pkg::HYP_TAB[n]};
      end
    end
  end

  assign valid_out = vld_r[tmp_pkg::CORDIC_STEPS];
  assign eps_z     = e_r[tmp_pkg::CORDIC_STEPS].z;
  assign p_z       = p_r[tmp_pkg::CORDIC_STEPS].z;
  assign q_z       = q_r[tmp_pkg::CORDIC_STEPS].z;

endmodule

// ===== rtl/transverse_mercator_projection_core.sv =====
`timescale 1ns / 1ps

// Spherical transverse Mercator projection: one latitude/longitude word in
// 1e-7 degree goes in on start and comes out as east/north centimeters with a
// saturation flag. The core takes a new word every cycle and busy stays low;
// each result appears on out_valid for a single cycle, in order, and must be
// taken then. The core is two chained 32-stage CORDIC pipelines (sine/cosine
// rotation, then atan/atanh vectoring) plus ten stages: input capture, scaling,
// CORDIC seeding and unfolding, products, preparation, combining, scaling to
// centimeters and rounding. Program origin_lat (0x0) and origin_lon (0x4) over
// the APB port only while no results are pending.
module transverse_mercator_projection_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Input words
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tmp_pkg::LAT_W-1:0]    in_lat_deg,
  input  logic signed [tmp_pkg::LON_W-1:0]    in_lon_deg,
  // Results
  output logic                                out_valid,
  output logic signed [tmp_pkg::OUT_W-1:0]    out_east_cm,
  output logic signed [tmp_pkg::OUT_W-1:0]    out_north_cm,
  output logic                                out_saturated
);

  localparam int   F     = tmp_pkg::ANGLE_FRAC_BITS;
  localparam int   TW    = tmp_pkg::TRIG_W;
  localparam int   EP_W  = tmp_pkg::NAB_W - 1 + tmp_pkg::RCM_W;
  localparam int   MAG_W = tmp_pkg::NAB_W - 1;

  typedef struct packed {
    logic           zero_div;
    logic           sp_pos;
    logic           sp_neg;
    logic           b_pos;
    logic           b_neg;
    logic [tmp_pkg::NORM_W-1:0] kp;
    logic [tmp_pkg::NORM_W-1:0] kq;
    tmp_pkg::word_t phi0;
  } side_t;

  // ---------------------------------------------------------------- config
  logic signed [tmp_pkg::LAT_W-1:0] origin_lat_r;
  logic signed [tmp_pkg::LON_W-1:0] origin_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lat_r <= '0;
      origin_lon_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        tmp_pkg::REG_ORIGIN_LAT: origin_lat_r <= pwdata[tmp_pkg::LAT_W-1:0];
        tmp_pkg::REG_ORIGIN_LON: origin_lon_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tmp_pkg::REG_ORIGIN_LAT: prdata = {1'b0, origin_lat_r};
      tmp_pkg::REG_ORIGIN_LON: prdata = origin_lon_r;
      default:                 prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // ---------------------------------------------------------------- helpers
  function automatic tmp_pkg::word_t rad_mul(input logic signed [tmp_pkg::LON_W:0] v);
    logic [tmp_pkg::LON_W:0]               mag;
    logic [tmp_pkg::LON_W+tmp_pkg::K_W:0]  prod;
    tmp_pkg::word_t                        r;
    mag  = v[tmp_pkg::LON_W] ? -v : v;
    prod = (tmp_pkg::LON_W + tmp_pkg::K_W + 1)'(mag)
         * (tmp_pkg::LON_W + tmp_pkg::K_W + 1)'(tmp_pkg::RAD_K);
    prod = prod + ((tmp_pkg::LON_W + tmp_pkg::K_W + 1)'(1) << (tmp_pkg::RAD_SHIFT - 1));
    r    = tmp_pkg::word_t'(prod >> tmp_pkg::RAD_SHIFT);
    return v[tmp_pkg::LON_W] ? -r : r;
  endfunction

  function automatic logic signed [TW-1:0] trig_mul(input logic signed [TW-1:0] a,
                                                    input logic signed [TW-1:0] b);
    logic [TW-1:0]   ma;
    logic [TW-1:0]   mb;
    logic [2*TW-1:0] prod;
    logic [TW-1:0]   mag;
    ma   = a[TW-1] ? -a : a;
    mb   = b[TW-1] ? -b : b;
    prod = (2*TW)'(ma) * (2*TW)'(mb);
    prod = prod + ((2*TW)'(1) << (F - 1));
    mag  = TW'(prod >> F);
    return (a[TW-1] ^ b[TW-1]) ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic [tmp_pkg::NORM_W-1:0] norm_shift(input tmp_pkg::word_t p);
    logic [tmp_pkg::NORM_W-1:0] pos;
    pos = '0;
    for (int j = 0; j <= F; j++) begin
      if (p[j]) pos = tmp_pkg::NORM_W'(j);
    end
    return tmp_pkg::NORM_W'(F) - pos;
  endfunction

  // ---------------------------------------------------------------- stage 1
  logic signed [tmp_pkg::LON_W:0] dl_raw;
  logic signed [tmp_pkg::LON_W:0] dl_wrap;
  logic                           s1_vld_r;
  logic signed [tmp_pkg::LON_W:0] s1_lat_r, s1_dl_r, s1_olat_r;

  // Take the longitude difference and wrap it once
  always_comb begin
    dl_raw = (tmp_pkg::LON_W+1)'(in_lon_deg) - (tmp_pkg::LON_W+1)'(origin_lon_r);
    if (dl_raw >= tmp_pkg::DL_HALF) begin
      dl_wrap = dl_raw - tmp_pkg::DL_FULL;
    end else if (dl_raw < -tmp_pkg::DL_HALF) begin
      dl_wrap = dl_raw + tmp_pkg::DL_FULL;
    end else begin
      dl_wrap = dl_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_lat_r  <= (tmp_pkg::LON_W+1)'(in_lat_deg);
    s1_dl_r   <= dl_wrap;
    s1_olat_r <= (tmp_pkg::LON_W+1)'(origin_lat_r);
  end

  // ---------------------------------------------------------------- stage 2
  logic           s2_vld_r;
  tmp_pkg::word_t s2_phi_r, s2_lam_r, s2_phi0_r;

  // Scale to radians
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_phi_r  <= rad_mul(s1_lat_r);
    s2_lam_r  <= rad_mul(s1_dl_r);
    s2_phi0_r <= rad_mul(s1_olat_r);
  end

  // ---------------------------------------------------------------- sin/cos
  tmp_pkg::word_t         phi0_fold;
  tmp_pkg::word_t         phi0_dly_r [tmp_pkg::SC_LAT];
  logic                   sc_vld;
  logic                   sc_vld_unused;
  logic signed [TW-1:0]   sp, cp, sl, cl;

  always_comb begin
    if (s2_phi0_r > tmp_pkg::HALF_PI_W) begin
      phi0_fold = s2_phi0_r - tmp_pkg::PI_W;
    end else if (s2_phi0_r < -tmp_pkg::HALF_PI_W) begin
      phi0_fold = s2_phi0_r + tmp_pkg::PI_W;
    end else begin
      phi0_fold = s2_phi0_r;
    end
  end

  // Carry the origin angle alongside the rotation pipes
  always_ff @(posedge clk) begin
    phi0_dly_r[0] <= phi0_fold;
    for (int k = 1; k < tmp_pkg::SC_LAT; k++) begin
      phi0_dly_r[k] <= phi0_dly_r[k-1];
    end
  end

  tmp_sincos u_sc_lat (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s2_vld_r),
    .angle     (s2_phi_r),
    .valid_out (sc_vld),
    .sin_out   (sp),
    .cos_out   (cp)
  );

  tmp_sincos u_sc_lon (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s2_vld_r),
    .angle     (s2_lam_r),
    .valid_out (sc_vld_unused),
    .sin_out   (sl),
    .cos_out   (cl)
  );

  // ---------------------------------------------------------------- products
  logic                 pr_vld_r;
  logic signed [TW-1:0] pr_d_r, pr_b_r, pr_sp_r;
  tmp_pkg::word_t       pr_phi0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else begin
      pr_vld_r <= sc_vld && sc_vld_unused;
    end
    pr_d_r    <= trig_mul(cp, cl);
    pr_b_r    <= trig_mul(cp[TW-1] ? -cp : cp, sl);
    pr_sp_r   <= sp;
    pr_phi0_r <= phi0_dly_r[tmp_pkg::SC_LAT-1];
  end

  // ---------------------------------------------------------------- prepare
  tmp_pkg::word_t d_w, sp_w, b_w, p_w, q_w;
  logic [tmp_pkg::NORM_W-1:0] kp, kq;
  side_t          side_nxt;

  logic           pq_vld_r;
  tmp_pkg::word_t pq_ex_r, pq_ey_r, pq_pm_r, pq_qm_r;
  side_t          pq_side_r;

  always_comb begin
    d_w  = tmp_pkg::word_t'(pr_d_r);
    sp_w = tmp_pkg::word_t'(pr_sp_r);
    b_w  = tmp_pkg::word_t'(pr_b_r);
    p_w  = tmp_pkg::ONE_W + b_w;
    q_w  = tmp_pkg::ONE_W - b_w;
    kp   = norm_shift(p_w);
    kq   = norm_shift(q_w);
    side_nxt.zero_div = (pr_d_r == '0);
    side_nxt.sp_pos   = !pr_sp_r[TW-1] && (pr_sp_r != '0);
    side_nxt.sp_neg   = pr_sp_r[TW-1];
    side_nxt.b_pos    = (b_w >= tmp_pkg::ONE_W);
    side_nxt.b_neg    = (b_w <= -tmp_pkg::ONE_W);
    side_nxt.kp       = kp;
    side_nxt.kq       = kq;
    side_nxt.phi0     = pr_phi0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pq_vld_r <= 1'b0;
    end else begin
      pq_vld_r <= pr_vld_r;
    end
    // Flip into the right half plane for the principal value
    if (pr_d_r[TW-1]) begin
      pq_ex_r <= -d_w;
      pq_ey_r <= -sp_w;
    end else begin
      pq_ex_r <= d_w;
      pq_ey_r <= sp_w;
    end
    pq_pm_r   <= p_w <<< kp;
    pq_qm_r   <= q_w <<< kq;
    pq_side_r <= side_nxt;
  end

  // ---------------------------------------------------------------- vectoring
  side_t          side_dly_r [tmp_pkg::VEC_LAT];
  logic           vec_vld;
  tmp_pkg::word_t eps_z, p_z, q_z;

  always_ff @(posedge clk) begin
    side_dly_r[0] <= pq_side_r;
    for (int k = 1; k < tmp_pkg::VEC_LAT; k++) begin
      side_dly_r[k] <= side_dly_r[k-1];
    end
  end

  tmp_vector u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (pq_vld_r),
    .eps_x     (pq_ex_r),
    .eps_y     (pq_ey_r),
    .p_norm    (pq_pm_r),
    .q_norm    (pq_qm_r),
    .valid_out (vec_vld),
    .eps_z     (eps_z),
    .p_z       (p_z),
    .q_z       (q_z)
  );

  // ---------------------------------------------------------------- combine
  side_t                       vs;
  tmp_pkg::word_t              eps_fin;
  logic signed [tmp_pkg::NORM_W:0] kdiff;

  logic           cb_vld_r;
  tmp_pkg::word_t cb_nab_r, cb_diff_r;
  logic           cb_bpos_r, cb_bneg_r, cb_zdiv_r;

  always_comb begin
    vs    = side_dly_r[tmp_pkg::VEC_LAT-1];
    kdiff = signed'({1'b0, vs.kq}) - signed'({1'b0, vs.kp});
    if (!vs.zero_div) begin
      eps_fin = eps_z;
    end else if (vs.sp_pos) begin
      eps_fin = tmp_pkg::HALF_PI_W;
    end else if (vs.sp_neg) begin
      eps_fin = -tmp_pkg::HALF_PI_W;
    end else begin
      eps_fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_vld_r <= 1'b0;
    end else begin
      cb_vld_r <= vec_vld;
    end
    cb_nab_r  <= p_z - q_z + tmp_pkg::word_t'(kdiff * tmp_pkg::HALF_LN2_W);
    cb_diff_r <= eps_fin - vs.phi0;
    cb_bpos_r <= vs.b_pos;
    cb_bneg_r <= vs.b_neg;
    cb_zdiv_r <= vs.zero_div;
  end

  // ---------------------------------------------------------------- scale
  logic [MAG_W-1:0] nab_mag, diff_mag;
  logic             ml_vld_r;
  logic [EP_W-1:0]  ml_east_r, ml_north_r;
  logic             ml_east_neg_r, ml_north_neg_r;
  logic             ml_bpos_r, ml_bneg_r, ml_zdiv_r;

  always_comb begin
    nab_mag  = cb_nab_r[tmp_pkg::WORD_W-1]  ? MAG_W'(-cb_nab_r)  : MAG_W'(cb_nab_r);
    diff_mag = cb_diff_r[tmp_pkg::WORD_W-1] ? MAG_W'(-cb_diff_r) : MAG_W'(cb_diff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_vld_r <= 1'b0;
    end else begin
      ml_vld_r <= cb_vld_r;
    end
    ml_east_r      <= EP_W'(nab_mag)  * EP_W'(tmp_pkg::R_CM);
    ml_north_r     <= EP_W'(diff_mag) * EP_W'(tmp_pkg::R_CM);
    ml_east_neg_r  <= cb_nab_r[tmp_pkg::WORD_W-1];
    ml_north_neg_r <= !cb_diff_r[tmp_pkg::WORD_W-1];
    ml_bpos_r      <= cb_bpos_r;
    ml_bneg_r      <= cb_bneg_r;
    ml_zdiv_r      <= cb_zdiv_r;
  end

  // ---------------------------------------------------------------- output
  logic [EP_W:0]                 east_rnd, north_rnd;
  logic                          east_clip, north_clip;
  logic signed [tmp_pkg::OUT_W-1:0] east_val, north_val, east_nxt, north_nxt;
  logic                          sat_nxt;

  logic                          out_vld_r;
  logic signed [tmp_pkg::OUT_W-1:0] out_east_r, out_north_r;
  logic                          out_sat_r;

  // Round, clip, apply the sign, rail east when |b| reaches one and flag saturation
  always_comb begin
    east_rnd   = ((EP_W+1)'(ml_east_r)  + ((EP_W+1)'(1) << (F - 1))) >> F;
    north_rnd  = ((EP_W+1)'(ml_north_r) + ((EP_W+1)'(1) << (F - 1))) >> F;
    east_clip  = east_rnd  > (EP_W+1)'(tmp_pkg::OUT_MAX);
    north_clip = north_rnd > (EP_W+1)'(tmp_pkg::OUT_MAX);
    east_val   = east_clip  ? tmp_pkg::OUT_MAX : tmp_pkg::OUT_W'(east_rnd);
    north_val  = north_clip ? tmp_pkg::OUT_MAX : tmp_pkg::OUT_W'(north_rnd);
    north_nxt  = ml_north_neg_r ? -north_val : north_val;
    if (ml_bpos_r) begin
      east_nxt = tmp_pkg::OUT_MAX;
    end else if (ml_bneg_r) begin
      east_nxt = -tmp_pkg::OUT_MAX;
    end else begin
      east_nxt = ml_east_neg_r ? -east_val : east_val;
    end
    sat_nxt = ml_zdiv_r || ml_bpos_r || ml_bneg_r || north_clip
           || (east_clip && !ml_bpos_r && !ml_bneg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= ml_vld_r;
    end
    out_east_r  <= east_nxt;
    out_north_r <= north_nxt;
    out_sat_r   <= sat_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_east_cm   = out_east_r;
  assign out_north_cm  = out_north_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== rtl/tmp_checker.sv =====
`timescale 1ns / 1ps

module tmp_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     pready,
  input logic                     out_valid,
  input logic signed [31:0]       out_east_cm,
  input logic signed [31:0]       out_north_cm
);

  // Every result traces back to a start word a fixed latency earlier
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, tmp_pkg::PIPE_LAT))
    else $error("result without a matching start word");

  // Saturation is symmetric, so the most negative code never shows
  a_east_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_east_cm != 32'sh8000_0000)
    else $error("east out of range");

  a_north_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_north_cm != 32'sh8000_0000)
    else $error("north out of range");

  // Configuration never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind transverse_mercator_projection_core tmp_checker u_tmp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .pready       (pready),
  .out_valid    (out_valid),
  .out_east_cm  (out_east_cm),
  .out_north_cm (out_north_cm)
);

// ===== tb/transverse_mercator_projection_core_tb.sv =====
`timescale 1ns / 1ps

module transverse_mercator_projection_core_tb;

  localparam int FRAC           = tmp_pkg::ANGLE_FRAC_BITS;
  localparam int STEPS          = tmp_pkg::CORDIC_STEPS;
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 2 * STEPS + 20;
  localparam longint OUT_LIM    = 64'sd2147483647;
  localparam longint R_CM_L     = 64'sd637300000;
  localparam longint unsigned Q62_ONE = 64'd1 << 62;
  localparam longint unsigned INV_GAIN_Q = 64'd2800459870029452954;

  typedef struct {
    logic signed [31:0] east;
    logic signed [31:0] north;
    logic               sat;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [tmp_pkg::LAT_W-1:0] in_lat_deg = '0;
  logic signed [tmp_pkg::LON_W-1:0] in_lon_deg = '0;
  logic out_valid;
  logic signed [tmp_pkg::OUT_W-1:0] out_east_cm;
  logic signed [tmp_pkg::OUT_W-1:0] out_north_cm;
  logic out_saturated;

  // Projection constants built in Q62; all but rad_k_c rounded to the angle format
  longint circ_ang [STEPS];
  longint hyp_ang [STEPS+1];
  longint pi_c, half_pi_c, half_ln2_c, inv_gain_c, rad_k_c;

  // Origin copy held by the predictor
  logic signed [30:0] org_lat = '0;
  logic signed [31:0] org_lon = '0;

  proj_t pending_proj [$];
  int errors = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  transverse_mercator_projection_core dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_lat_deg(in_lat_deg), .in_lon_deg(in_lon_deg),
    .out_valid(out_valid), .out_east_cm(out_east_cm),
    .out_north_cm(out_north_cm), .out_saturated(out_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned series_sum(longint unsigned p0, int sh,
                                                 longint unsigned dv, bit alt);
    longint unsigned p, acc, k, term;
    p = p0;
    acc = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (alt && k[0]) acc -= term;
      else acc += term;
      if (dv != 0) p = p / dv;
      else p = p >> sh;
      k++;
    end
    return acc;
  endfunction

  function automatic longint q62_round(longint unsigned v);
    return longint'((v + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
  endfunction

  function automatic void build_constants();
    longint unsigned pi4, pi62;
    pi4 = 4 * series_sum(Q62_ONE / 5, 0, 25, 1) - series_sum(Q62_ONE / 239, 0, 57121, 1);
    pi62 = 4 * pi4;
    circ_ang[0] = q62_round(pi4);
    hyp_ang[0] = 0;
    for (int i = 1; i <= STEPS; i++) begin
      if (i < STEPS) circ_ang[i] = q62_round(series_sum(Q62_ONE >> i, 2 * i, 0, 1));
      hyp_ang[i] = q62_round(series_sum(Q62_ONE >> i, 2 * i, 0, 0));
    end
    pi_c = q62_round(pi62);
    half_pi_c = q62_round(2 * pi4);
    half_ln2_c = q62_round(series_sum(Q62_ONE / 3, 0, 9, 0));
    inv_gain_c = q62_round(INV_GAIN_Q);
    rad_k_c = longint'((pi62 + 64'd900000000) / 64'd1800000000);
  endfunction

  // Signed product, rounded half away from zero, magnitude capped
  function automatic longint mul_round(longint a, longint b, int sh);
    logic [127:0] pr;
    longint unsigned ua, ub;
    longint r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    pr = {64'd0, ua} * {64'd0, ub};
    pr = (pr + (128'd1 << (sh - 1))) >> sh;
    if (pr > 128'h7FFF_FFFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF_FFFF;
    else r = longint'(pr[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic void rotate_sin_cos(longint ang, output longint s, output longint c);
    longint x, y, a, dx, dy;
    bit flip;
    x = inv_gain_c;
    y = 0;
    a = ang;
    flip = 1'b0;
    if (a > half_pi_c) begin
      a -= pi_c;
      flip = 1'b1;
    end else if (a < -half_pi_c) begin
      a += pi_c;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= circ_ang[i];
      end else begin
        x += dx; y -= dy; a += circ_ang[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_atan(longint x0, longint y0);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += circ_ang[i];
      end else begin
        x -= dx; y += dy; z -= circ_ang[i];
      end
    end
    return z;
  endfunction

  // atanh((m-1)/(m+1)) with repeated shifts 4 and 13
  function automatic longint vector_atanh(longint m);
    longint x, y, z, dx, dy;
    int i, rep;
    bit again;
    x = m + (64'sd1 << FRAC);
    y = m - (64'sd1 << FRAC);
    z = 0;
    i = 1;
    rep = 4;
    again = 1'b0;
    for (int n = 0; n < STEPS; n++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x -= dx; y -= dy; z += hyp_ang[i];
      end else begin
        x += dx; y += dy; z -= hyp_ang[i];
      end
      if (i == rep && !again) begin
        again = 1'b1;
      end else begin
        if (i == rep) begin
          rep = 3 * rep + 1;
          again = 1'b0;
        end
        i++;
      end
    end
    return z;
  endfunction

  function automatic longint clip_cm(longint v, inout logic sat);
    if (v > OUT_LIM) begin
      sat = 1'b1;
      return OUT_LIM;
    end
    if (v < -OUT_LIM) begin
      sat = 1'b1;
      return -OUT_LIM;
    end
    return v;
  endfunction

  function automatic proj_t project_point(logic signed [30:0] la, logic signed [31:0] lo);
    proj_t r;
    longint one, dl, phi, lam, phi0, sp, cp, sl, cl, d, eps, b, east, north;
    longint p, q, kp, kq, nab;
    logic sat;
    one = 64'sd1 << FRAC;
    sat = 1'b0;
    dl = longint'(lo) - longint'(org_lon);
    if (dl >= 64'sd1800000000) dl -= 64'sd3600000000;
    else if (dl < -64'sd1800000000) dl += 64'sd3600000000;
    phi = mul_round(longint'(la), rad_k_c, 62 - FRAC);
    lam = mul_round(dl, rad_k_c, 62 - FRAC);
    phi0 = mul_round(longint'(org_lat), rad_k_c, 62 - FRAC);
    rotate_sin_cos(phi, sp, cp);
    rotate_sin_cos(lam, sl, cl);
    // eps, with the zero divisor case pinned to the pole or the equator
    d = mul_round(cp, cl, FRAC);
    if (d == 0) begin
      sat = 1'b1;
      eps = (sp > 0) ? half_pi_c : ((sp < 0) ? -half_pi_c : 0);
    end else if (d < 0) begin
      eps = vector_atan(-d, -sp);
    end else begin
      eps = vector_atan(d, sp);
    end
    if (phi0 > half_pi_c) phi0 -= pi_c;
    else if (phi0 < -half_pi_c) phi0 += pi_c;
    // nab from normalized atanh pair; |b| at one goes to the rail
    b = mul_round((cp < 0) ? -cp : cp, sl, FRAC);
    if (b >= one) begin
      sat = 1'b1;
      east = OUT_LIM;
    end else if (b <= -one) begin
      sat = 1'b1;
      east = -OUT_LIM;
    end else begin
      p = one + b;
      q = one - b;
      kp = 0;
      kq = 0;
      while (p < one) begin
        p = p <<< 1; kp++;
      end
      while (q < one) begin
        q = q <<< 1; kq++;
      end
      nab = vector_atanh(p) - vector_atanh(q) + (kq - kp) * half_ln2_c;
      east = clip_cm(mul_round(nab, R_CM_L, FRAC), sat);
    end
    north = clip_cm(-mul_round(eps - phi0, R_CM_L, FRAC), sat);
    r.east = east[31:0];
    r.north = north[31:0];
    r.sat = sat;
    return r;
  endfunction

  // Predict on every accepted word
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pending_proj.push_back(project_point(in_lat_deg, in_lon_deg));
      words_sent++;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    proj_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_saturated) sat_seen++;
      if (pending_proj.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result east=%0d north=%0d sat=%0b", $realtime,
                   out_east_cm, out_north_cm, out_saturated);
      end else begin
        exp_r = pending_proj.pop_front();
        if (out_east_cm !== exp_r.east || out_north_cm !== exp_r.north ||
            out_saturated !== exp_r.sat) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp east=%0d north=%0d sat=%0b got east=%0d north=%0d sat=%0b",
                     $realtime, exp_r.east, exp_r.north, exp_r.sat,
                     out_east_cm, out_north_cm, out_saturated);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(tmp_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == tmp_pkg::REG_ORIGIN_LAT) org_lat = val[30:0];
    else if (idx == tmp_pkg::REG_ORIGIN_LON) org_lon = val;
  endtask

  // Send one word after a random gap; hold start across back-to-back words
  task automatic send_point(logic signed [30:0] la, logic signed [31:0] lo);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_lat_deg <= la;
    in_lon_deg <= lo;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (pending_proj.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_origin(logic [31:0] lat, logic [31:0] lon);
    drain();
    cfg_write(tmp_pkg::REG_ORIGIN_LAT, lat);
    cfg_write(tmp_pkg::REG_ORIGIN_LON, lon);
  endtask

  // Poles, equator, quarter and half turns, zero divisor and infinite nab
  task automatic test_directed();
    send_point(31'sd0, 32'sd0);
    send_point(31'sd900000000, 32'sd0);
    send_point(-31'sd900000000, 32'sd0);
    send_point(31'sd0, 32'sd900000000);
    send_point(31'sd0, -32'sd900000000);
    send_point(31'sd0, 32'sd1800000000);
    send_point(31'sd0, -32'sd1800000000);
    send_point(31'sd900000000, 32'sd900000000);
    send_point(-31'sd900000000, -32'sd900000000);
    send_point(31'sd450000000, 32'sd899999999);
    send_point(31'sd0, 32'sd899999999);
    send_point(31'sd100, 32'sd900000000);
    send_point(-31'sd100, -32'sd900000000);
    send_point(31'sd600000000, 32'sd1799999999);
    send_point(31'sd1, 32'sd1);
    send_point(-31'sd1, -32'sd1);
    send_point(31'h3FFF_FFFF, 32'h7FFF_FFFF);
    send_point(31'h4000_0000, 32'h8000_0000);
    send_point(31'sd899999999, -32'sd1799999999);
  endtask

  // Half in-range points, some near the poles or the equator at the quarter meridian, some raw noise
  task automatic test_random_points(int count);
    longint la, lo;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        la = longint'($urandom());
        lo = longint'($urandom());
      end else if (kind < 7) begin
        la = longint'($urandom_range(0, 1800000000)) - 900000000;
        lo = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
      end else begin
        la = $urandom_range(0, 1) ? 900000000 - longint'($urandom_range(0, 2000))
                                  : longint'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 1)) la = -la;
        lo = longint'(org_lon) + ($urandom_range(0, 1) ? 900000000 : -900000000)
             + longint'($urandom_range(0, 4000)) - 2000;
      end
      send_point(la[30:0], lo[31:0]);
    end
  endtask

  initial begin
    build_constants();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_points(320);

    set_origin(32'sd900000000, 32'sd1800000000);
    test_random_points(320);

    set_origin(-32'sd900000000, -32'sd1800000000);
    test_directed();
    test_random_points(320);

    // origin beyond the poles, folded back by pi
    set_origin(32'h3FFF_FFFF, 32'sd123456789);
    test_random_points(320);

    set_origin(32'hC000_0000, 32'h8000_0000);
    test_random_points(320);

    set_origin($urandom(), $urandom());
    test_random_points(320);

    drain();
    errors += pending_proj.size();
    $display("Sent %0d words over six origin settings, %0d results checked (%0d saturated)",
             words_sent, results_seen, sat_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
